// ----- hdl/sde_pkg.sv -----
// shared types and constants for the stream delimiter extractor
package sde_pkg;

	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 16;

	localparam int START_LEN = 6;
	localparam int END_LEN   = 9;

	// oldest byte sits in the most significant position of a window
	localparam logic [START_LEN*BYTE_W-1:0] START_PAT = "stream";
	localparam logic [END_LEN*BYTE_W-1:0]   END_PAT   = "endstream";

	localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

	typedef enum logic {
		EV_DATA  = 1'b0,
		EV_START = 1'b1
	} event_t;

	typedef struct packed {
		event_t              event_res;
		logic [BYTE_W-1:0]   out_byte;
		logic [INDEX_W-1:0]  stream_index;
		logic                end_of_stream;
	} result_t;

endpackage

// ----- hdl/sde_in_if.sv -----
// input channel: one document byte per word
interface sde_in_if import sde_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hdl/sde_out_if.sv -----
// output channel: start events and forwarded stream bytes
interface sde_out_if import sde_pkg::*; ;
	logic               valid;
	logic               ready;
	event_t             event_res;
	logic [BYTE_W-1:0]  out_byte;
	logic [INDEX_W-1:0] stream_index;
	logic               end_of_stream;

	modport source (output valid, output event_res, output out_byte,
		output stream_index, output end_of_stream, input ready);
	modport sink (input valid, input event_res, input out_byte,
		input stream_index, input end_of_stream, output ready);
endinterface

// ----- hdl/sde_scan.sv -----
// delimiter windows, stream mode state and per-byte result logic
module sde_scan import sde_pkg::*; #(
	parameter int LEADING_SKIP = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              res_valid,
	output result_t           res
);

	localparam int POS_W = (LEADING_SKIP > 0) ? $clog2(LEADING_SKIP + 1) : 1;
	localparam logic [POS_W-1:0] SKIP_LIM = POS_W'(LEADING_SKIP);

	logic [START_LEN*BYTE_W-1:0] start_win_q, start_win_d;
	logic [END_LEN*BYTE_W-1:0]   end_win_q, end_win_d;
	logic                        inside_q, inside_d;
	logic [POS_W-1:0]            pos_q, pos_d;
	logic [INDEX_W-1:0]          count_q, count_d;

	logic start_hit;
	logic end_hit;
	logic skip;

	always_comb begin
		start_win_d = start_win_q;
		end_win_d   = end_win_q;
		inside_d    = inside_q;
		pos_d       = pos_q;
		count_d     = count_q;
		res_valid   = 1'b0;
		res         = '{event_res: EV_DATA, out_byte: data_byte,
			stream_index: count_q, end_of_stream: 1'b0};

		start_hit = 1'b0;
		end_hit   = 1'b0;
		skip      = 1'b0;

		if (!inside_q) begin
			start_win_d = {start_win_q[(START_LEN-1)*BYTE_W-1:0], data_byte};
			start_hit   = (start_win_d == START_PAT);
			if (start_hit) begin
				end_win_d         = '0;
				pos_d             = '0;
				inside_d          = 1'b1;
				res_valid         = 1'b1;
				res.event_res     = EV_START;
				res.out_byte      = '0;
			end
		end else begin
			skip      = (pos_q < SKIP_LIM) && (data_byte == BYTE_LF || data_byte == BYTE_CR);
			end_win_d = {end_win_q[(END_LEN-1)*BYTE_W-1:0], data_byte};
			end_hit   = (end_win_d == END_PAT);
			if (pos_q < SKIP_LIM) begin
				pos_d = pos_q + POS_W'(1);
			end
			res.end_of_stream = end_hit;
			res_valid         = !skip || end_hit;
			if (end_hit) begin
				inside_d = 1'b0;
				count_d  = count_q + INDEX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_win_q <= '0;
			end_win_q   <= '0;
			inside_q    <= 1'b0;
			pos_q       <= '0;
			count_q     <= '0;
		end else if (step) begin
			start_win_q <= start_win_d;
			end_win_q   <= end_win_d;
			inside_q    <= inside_d;
			pos_q       <= pos_d;
			count_q     <= count_d;
		end
	end

endmodule

// ----- hdl/stream_delimiter_extractor_unit.sv -----
// top level of the stream delimiter extractor
//
// byte_in takes one raw document byte per word; result gives one word per
// start delimiter ("stream" seen outside a stream, event_res = start) and
// one per byte inside a stream (event_res = data, with end_of_stream set
// on the byte that completes "endstream"). a line break among the first
// LEADING_SKIP bytes of a stream gives no word.
// a byte accepted from byte_in goes into the input register; its word goes
// into the result register when the byte is processed, which waits while
// the result register holds a word that result has not taken.
// throughput: one byte per cycle, sustained, while result is taken.
// when result stalls the finished word holds in the result register and
// one more byte waits in the input register; byte_in.ready then drops.
// the held byte waits for result even when it would give no word.
// reset (arst_n low) empties both registers, clears both windows, leaves
// stream mode and sets the stream number to zero.
module stream_delimiter_extractor_unit import sde_pkg::*; #(
	parameter int LEADING_SKIP = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	sde_in_if.sink    byte_in,
	sde_out_if.source result
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic    out_valid_q;
	result_t out_q;

	logic    advance;     // result register can take a new word
	logic    step;        // held byte is processed this cycle
	logic    res_valid;
	result_t res;

	assign advance       = !out_valid_q || result.ready;
	assign step          = valid_s1 && advance;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	// window match and stream state
	sde_scan #(
		.LEADING_SKIP(LEADING_SKIP)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.event_res     = out_q.event_res;
	assign result.out_byte      = out_q.out_byte;
	assign result.stream_index  = out_q.stream_index;
	assign result.end_of_stream = out_q.end_of_stream;

endmodule

// ----- dv/delimiter_checker.sv -----
// checker for the stream delimiter extractor: predicts each result word and compares
module delimiter_checker import sde_pkg::*; #(
	parameter int LEADING_SKIP = 2
) (
	input  logic clk,
	input  logic arst_n,
	sde_in_if    byte_in,
	sde_out_if   result,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 100;

	logic [START_LEN*BYTE_W-1:0] start_win;
	logic [END_LEN*BYTE_W-1:0]   end_win;
	logic                        in_stream;
	logic [1:0]                  lead_pos;
	logic [INDEX_W-1:0]          stream_no;

	result_t expected_words[$];

	// advances the predicted state by one byte; returns 1 when a word comes out
	function automatic bit predict_word(input logic [BYTE_W-1:0] b, output result_t word);
		bit skip;
		bit last;
		word = '0;
		if (!in_stream) begin
			start_win = {start_win[(START_LEN-1)*BYTE_W-1:0], b};
			if (start_win != START_PAT)
				return 1'b0;
			end_win = '0;
			lead_pos = '0;
			in_stream = 1'b1;
			word.event_res = EV_START;
			word.stream_index = stream_no;
			return 1'b1;
		end
		skip = (lead_pos < LEADING_SKIP) && (b == BYTE_LF || b == BYTE_CR);
		end_win = {end_win[(END_LEN-1)*BYTE_W-1:0], b};
		last = (end_win == END_PAT);
		if (lead_pos < LEADING_SKIP && lead_pos < 3)
			lead_pos = lead_pos + 2'd1;
		word.event_res = EV_DATA;
		word.out_byte = b;
		word.stream_index = stream_no;
		word.end_of_stream = last;
		if (last) begin
			in_stream = 1'b0;
			stream_no = stream_no + 1'b1;
		end
		return !(skip && !last);
	endfunction

	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			if (errors < MAX_REPORTS)
				$display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			start_win = '0;
			end_win = '0;
			in_stream = 1'b0;
			lead_pos = '0;
			stream_no = '0;
			expected_words.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// a word leaving at this edge can't come from a byte taken at the same edge
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t ns: word expected none got event %0d byte %0h index %0h end %0b",
							$time, result.event_res, result.out_byte, result.stream_index,
							result.end_of_stream);
					errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("event_res", 16'(want.event_res), 16'(result.event_res));
					check_field("out_byte", 16'(want.out_byte), 16'(result.out_byte));
					check_field("stream_index", want.stream_index, result.stream_index);
					check_field("end_of_stream", 16'(want.end_of_stream),
						16'(result.end_of_stream));
				end
			end
			if (byte_in.valid && byte_in.ready) begin
				if (predict_word(byte_in.data_byte, want))
					expected_words.push_back(want);
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// top of the stream delimiter extractor testbench: stimulus, clock, reset and verdict
module testbench import sde_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEAD_SKIP   = 2;
	// CYCLE_LIMIT covers the whole run even with both sides idling
	localparam int CYCLE_LIMIT = 50_000;
	localparam int DRAIN_LIMIT = 2000;
	localparam int PHASE_BYTES = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_sent = 0;
	int cycle_count = 0;
	int errors;
	int pending;

	sde_in_if  byte_in();
	sde_out_if result();

	stream_delimiter_extractor_unit #(
		.LEADING_SKIP(LEAD_SKIP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_in),
		.result (result)
	);

	delimiter_checker #(
		.LEADING_SKIP(LEAD_SKIP)
	) checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_in),
		.result (result),
		.errors (errors),
		.pending(pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case a word never shows up or the block hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: errors");
		$finish;
	end

	// receiver side: a fresh ready decision every cycle, stall rate set by the phase
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// offer one word, with random idle cycles in front, and hold it until taken
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// first n characters of a delimiter, oldest character in the top byte
	task automatic send_head(input logic [END_LEN*BYTE_W-1:0] pat, input int len,
		input int n);
		for (int k = 0; k < n; k++)
			send_byte(pat[(len-1-k)*BYTE_W +: BYTE_W]);
	endtask

	function automatic logic [BYTE_W-1:0] line_break();
		return $urandom_range(1) ? BYTE_LF : BYTE_CR;
	endfunction

	// stream body content leans on delimiter letters and line breaks
	function automatic logic [BYTE_W-1:0] body_byte();
		case ($urandom_range(5))
			0, 1: return BYTE_W'($urandom_range(255));
			2, 3: return END_PAT[$urandom_range(END_LEN-1)*BYTE_W +: BYTE_W];
			4: return line_break();
			default: return $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// one random chunk of document: mostly whole streams, some noise and broken delimiters
	task automatic send_chunk();
		int kind;
		int n;
		kind = $urandom_range(9);
		if (kind == 0) begin
			// plain noise outside any stream
			n = $urandom_range(8, 1);
			repeat (n) send_byte(BYTE_W'($urandom_range(255)));
		end else if (kind == 1) begin
			// start delimiter cut short
			send_head((END_LEN*BYTE_W)'(START_PAT), START_LEN,
				$urandom_range(START_LEN-1, 1));
			send_byte(BYTE_W'($urandom_range(255)));
		end else begin
			n = $urandom_range(3);
			repeat (n) send_byte(BYTE_W'($urandom_range(255)));
			send_head((END_LEN*BYTE_W)'(START_PAT), START_LEN, START_LEN);
			// leading line breaks: first two dropped, a third one goes through
			if ($urandom_range(1)) begin
				n = $urandom_range(3, 1);
				repeat (n) send_byte(line_break());
			end
			n = $urandom_range(12);
			repeat (n) begin
				if ($urandom_range(7) == 0) begin
					// end delimiter that breaks off partway
					send_head(END_PAT, END_LEN, $urandom_range(END_LEN-1, 1));
					send_byte(BYTE_W'($urandom_range(255)));
				end else begin
					send_byte(body_byte());
				end
			end
			// now and then leave the stream open into the next chunk
			if ($urandom_range(9) != 0)
				send_head(END_PAT, END_LEN, END_LEN);
		end
	endtask

	initial begin : stimulus
		int drain;
		byte_in.valid <= 1'b0;
		byte_in.data_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, a start, leading line breaks, a line break past
		// the skip window, then the end delimiter
		send_byte(8'h00);
		send_byte(8'hFF);
		send_head((END_LEN*BYTE_W)'(START_PAT), START_LEN, START_LEN);
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
		send_byte(BYTE_LF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_head(END_PAT, END_LEN, END_LEN);

		// random part: no idling, sender gaps, receiver stalls, then both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES)
				send_chunk();
		end
		byte_in.valid <= 1'b0;

		// let the last words come out, then keep the clock running to catch any stray word
		drain = 0;
		while (pending != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
